### src/blvr_pkg.sv
// Shared constants, command and status codes, and beat types for the bounded list.
`default_nettype none

package blvr_pkg;

    localparam int DEPTH = 32;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_DEL_FIRST  = 3'd4;
    localparam logic [2:0] CMD_DEL_ALL    = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic        [2:0]  command;
        logic signed [31:0] element_value;
    } t_in_beat;

    typedef struct packed {
        logic        [1:0]  status;
        logic        [5:0]  removed_count;
        logic        [5:0]  list_length;
        logic signed [31:0] head_value;
        logic signed [31:0] tail_value;
    } t_out_beat;

endpackage

`default_nettype wire

### src/bounded_list_with_value_removal.sv
// Top level of the bounded double-ended list with delete by value.
//
// Holds up to DEPTH signed 32-bit entries in a circular store with one write and one
// registered read port. One command is taken at a time; o_stall is high while it is at
// work. Pushes, pops, unused codes and any command on an empty list pass from acceptance
// to the result beat through head read, tail read, capture and output load. Both delete
// commands on a non-empty list scan it through the single read port, one entry per cycle,
// compacting in place as they go, then pass through the same steps to the result beat.
// A result beat still waiting on the output holds the output load of the next one back.
// The next command may be accepted while a result beat is still held on the output side.
// No clearing pass is needed after reset.
`default_nettype none

module bounded_list_with_value_removal (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire blvr_pkg::t_in_beat  i_data,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output blvr_pkg::t_out_beat      o_data
);

    import blvr_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_RDH  = 3'd2;
    localparam logic [2:0] S_RDT  = 3'd3;
    localparam logic [2:0] S_CAPT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]         r_state,     n_state;
    logic [CW-1:0]      r_count,     n_count;
    logic [AW-1:0]      r_front,     n_front;
    logic [CW-1:0]      r_rd,        n_rd;
    logic [CW-1:0]      r_wr,        n_wr;
    logic               r_pend,      n_pend;
    logic               r_del_all,   n_del_all;
    logic [31:0]        r_val,       n_val;
    logic [1:0]         r_status,    n_status;
    logic [CW-1:0]      r_removed,   n_removed;
    logic [31:0]        r_head,      n_head;
    logic [31:0]        r_tail,      n_tail;
    logic               r_out_valid, n_out_valid;
    t_out_beat          r_out,       n_out;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [31:0]        ram_rdata;
    logic               full;
    logic               empty;
    logic               drop;
    logic [CW-1:0]      last_idx;
    logic [AW-1:0]      front_dec;
    logic [AW-1:0]      front_inc;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                              input logic [CW-1:0] idx);
        logic [CW:0] s;
        begin
            s = (CW+1)'(front) + (CW+1)'(idx);
            if (s >= (CW+1)'(DEPTH)) begin
                s = s - (CW+1)'(DEPTH);
            end
            return AW'(s);
        end
    endfunction

    blvr_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign last_idx  = empty ? '0 : r_count - CW'(1);
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);
    assign drop      = (ram_rdata == r_val) && (r_del_all || (r_removed == '0));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_front     = r_front;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_pend      = r_pend;
        n_del_all   = r_del_all;
        n_val       = r_val;
        n_status    = r_status;
        n_removed   = r_removed;
        n_head      = r_head;
        n_tail      = r_tail;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = r_val;
        ram_raddr   = '0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_val     = i_data.element_value;
                    n_status  = ST_OK;
                    n_removed = '0;
                    n_state   = S_RDH;
                    unique case (i_data.command)
                        CMD_PUSH_FRONT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_front   = front_dec;
                                ram_we    = 1'b1;
                                ram_waddr = front_dec;
                                ram_wdata = i_data.element_value;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        CMD_PUSH_BACK: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = slot_of(r_front, r_count);
                                ram_wdata = i_data.element_value;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_front   = front_inc;
                                n_count   = r_count - CW'(1);
                                n_removed = CW'(1);
                            end
                        end
                        CMD_POP_BACK: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count   = r_count - CW'(1);
                                n_removed = CW'(1);
                            end
                        end
                        CMD_DEL_FIRST, CMD_DEL_ALL: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_del_all = (i_data.command == CMD_DEL_ALL);
                                n_rd      = '0;
                                n_wr      = '0;
                                n_pend    = 1'b0;
                                n_state   = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!r_pend && (r_rd == r_count)) begin
                    n_count  = r_wr;
                    n_status = (r_removed == '0) ? ST_MISSING : ST_OK;
                    n_state  = S_RDH;
                end else begin
                    if (r_rd < r_count) begin
                        ram_raddr = slot_of(r_front, r_rd);
                        n_rd      = r_rd + CW'(1);
                        n_pend    = 1'b1;
                    end else begin
                        n_pend = 1'b0;
                    end
                    if (r_pend) begin
                        if (drop) begin
                            n_removed = r_removed + CW'(1);
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = slot_of(r_front, r_wr);
                            ram_wdata = ram_rdata;
                            n_wr      = r_wr + CW'(1);
                        end
                    end
                end
            end
            S_RDH: begin
                ram_raddr = slot_of(r_front, '0);
                n_state   = S_RDT;
            end
            S_RDT: begin
                n_head    = ram_rdata;
                ram_raddr = slot_of(r_front, last_idx);
                n_state   = S_CAPT;
            end
            S_CAPT: begin
                n_tail  = ram_rdata;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    n_out.status        = r_status;
                    n_out.removed_count = 6'(r_removed);
                    n_out.list_length   = 6'(r_count);
                    n_out.head_value    = empty ? '0 : r_head;
                    n_out.tail_value    = empty ? '0 : r_tail;
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_front     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_front     <= n_front;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_rd      <= n_rd;
        r_wr      <= n_wr;
        r_del_all <= n_del_all;
        r_val     <= n_val;
        r_status  <= n_status;
        r_removed <= n_removed;
        r_head    <= n_head;
        r_tail    <= n_tail;
        r_out     <= n_out;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("list length beyond depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("not busy after accepting a beat");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_wr <= r_rd))
        else $error("compaction write index ahead of read index");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.status == ST_EMPTY)) |->
            ((o_data.removed_count == '0) && (o_data.list_length == '0)))
        else $error("empty status with entries removed or held");
`endif

endmodule

`default_nettype wire

### src/blvr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module blvr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sim/blvr_checker.sv
// Watches both channels of the bounded list, predicts every result beat and compares it.
`default_nettype none

module blvr_checker
    import blvr_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cmd_valid,
    input  wire logic      i_cmd_stall,
    input  wire t_in_beat  i_cmd_beat,
    input  wire logic      i_res_valid,
    input  wire logic      i_res_stall,
    input  wire t_out_beat i_res_beat,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_result_count,
    output int             o_full_count,
    output int             o_empty_count,
    output int             o_missing_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] held_entries[$];
    t_out_beat   pending_results[$];

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_result_count  = 0;
        o_full_count    = 0;
        o_empty_count   = 0;
        o_missing_count = 0;
    end

    function automatic t_out_beat apply_command(input t_in_beat beat);
        t_out_beat   res;
        logic [31:0] kept[$];
        int          hit;
        res = '0;
        res.status = ST_OK;
        hit = -1;
        case (beat.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (held_entries.size() >= DEPTH)
                    res.status = ST_FULL;
                else if (beat.command == CMD_PUSH_FRONT)
                    held_entries.push_front(beat.element_value);
                else
                    held_entries.push_back(beat.element_value);
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (held_entries.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    if (beat.command == CMD_POP_FRONT)
                        void'(held_entries.pop_front());
                    else
                        void'(held_entries.pop_back());
                    res.removed_count = 6'd1;
                end
            end
            CMD_DEL_FIRST: begin
                if (held_entries.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    foreach (held_entries[k])
                        if (hit < 0 && held_entries[k] == beat.element_value)
                            hit = k;
                    if (hit < 0) begin
                        res.status = ST_MISSING;
                    end else begin
                        held_entries.delete(hit);
                        res.removed_count = 6'd1;
                    end
                end
            end
            CMD_DEL_ALL: begin
                if (held_entries.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    foreach (held_entries[k])
                        if (held_entries[k] == beat.element_value)
                            res.removed_count = res.removed_count + 6'd1;
                        else
                            kept.push_back(held_entries[k]);
                    held_entries = kept;
                    if (res.removed_count == 6'd0)
                        res.status = ST_MISSING;
                end
            end
            default: ;
        endcase
        res.list_length = 6'(held_entries.size());
        if (held_entries.size() != 0) begin
            res.head_value = held_entries[0];
            res.tail_value = held_entries[$];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            held_entries.delete();
            pending_results.delete();
        end else begin
            if (i_cmd_valid && !i_cmd_stall)
                pending_results.push_back(apply_command(i_cmd_beat));
            if (i_res_valid && !i_res_stall) begin
                o_result_count++;
                if (pending_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: result beat with nothing expected: st=%0d rm=%0d len=%0d head=%h tail=%h",
                                 $realtime, i_res_beat.status, i_res_beat.removed_count,
                                 i_res_beat.list_length, i_res_beat.head_value,
                                 i_res_beat.tail_value);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    case (want.status)
                        ST_FULL:    o_full_count++;
                        ST_EMPTY:   o_empty_count++;
                        ST_MISSING: o_missing_count++;
                        default: ;
                    endcase
                    if (i_res_beat.status !== want.status
                        || i_res_beat.removed_count !== want.removed_count
                        || i_res_beat.list_length !== want.list_length
                        || i_res_beat.head_value !== want.head_value
                        || i_res_beat.tail_value !== want.tail_value) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: mismatch on result %0d", $realtime, o_result_count);
                            $display("  expected st=%0d rm=%0d len=%0d head=%h tail=%h",
                                     want.status, want.removed_count, want.list_length,
                                     want.head_value, want.tail_value);
                            $display("  actual   st=%0d rm=%0d len=%0d head=%h tail=%h",
                                     i_res_beat.status, i_res_beat.removed_count,
                                     i_res_beat.list_length, i_res_beat.head_value,
                                     i_res_beat.tail_value);
                        end
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = pending_results.size();
    end

endmodule

`default_nettype wire

### sim/tb_top.sv
// Testbench top: clock, reset, command stimulus, output back-pressure and the verdict.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import blvr_pkg::*;

    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;
    localparam int         ITEM_TARGET = 1750;
    localparam int         POOL_SIZE   = 6;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} t_burst_mode;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    t_in_beat  cmd_beat  = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    t_out_beat res_beat;

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int sent_count    = 0;
    int spare_count   = 0;

    int chk_fail;
    int chk_pending;
    int chk_results;
    int chk_full;
    int chk_empty;
    int chk_missing;

    logic [31:0] value_pool[POOL_SIZE];

    bounded_list_with_value_removal dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (cmd_valid),
        .o_stall (cmd_stall),
        .i_data  (cmd_beat),
        .o_valid (res_valid),
        .i_stall (res_stall),
        .o_data  (res_beat)
    );

    blvr_checker list_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cmd_valid     (cmd_valid),
        .i_cmd_stall     (cmd_stall),
        .i_cmd_beat      (cmd_beat),
        .i_res_valid     (res_valid),
        .i_res_stall     (res_stall),
        .i_res_beat      (res_beat),
        .o_fail_count    (chk_fail),
        .o_pending       (chk_pending),
        .o_result_count  (chk_results),
        .o_full_count    (chk_full),
        .o_empty_count   (chk_empty),
        .o_missing_count (chk_missing)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        res_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    task automatic send_command(input logic [2:0] cmd, input logic [31:0] val);
        t_in_beat beat;
        beat.command       = cmd;
        beat.element_value = val;
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_beat  <= beat;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        if (cmd == CMD_SPARE_A || cmd == CMD_SPARE_B)
            spare_count++;
        else
            sent_count++;
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] edges[4];
        edges = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        case ($urandom_range(9))
            0:       return edges[$urandom_range(3)];
            1, 2, 3: return $urandom();
            default: return value_pool[$urandom_range(POOL_SIZE - 1)];
        endcase
    endfunction

    function automatic logic [2:0] pick_command(input t_burst_mode mode);
        int r;
        int push_pct;
        r = $urandom_range(99);
        if (r < 2)
            return $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
        case (mode)
            MODE_FILL:  push_pct = 80;
            MODE_DRAIN: push_pct = 30;
            default:    push_pct = 34;
        endcase
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        case ($urandom_range(3))
            0:       return CMD_POP_FRONT;
            1:       return CMD_POP_BACK;
            2:       return CMD_DEL_FIRST;
            default: return CMD_DEL_ALL;
        endcase
    endfunction

    task automatic run_bursts(input int quota);
        int          done;
        int          burst_len;
        t_burst_mode mode;
        logic [2:0]  cmd;
        done = 0;
        while (done < quota) begin
            mode = t_burst_mode'($urandom_range(2));
            burst_len = $urandom_range(80, 20);
            foreach (value_pool[k])
                value_pool[k] = $urandom_range(1) ? $urandom() : 32'($urandom_range(5));
            repeat (burst_len) begin
                if (done < quota) begin
                    cmd = pick_command(mode);
                    send_command(cmd, pick_value());
                    if (cmd != CMD_SPARE_A && cmd != CMD_SPARE_B)
                        done++;
                end
            end
        end
    endtask

    initial begin
        int quota;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-list cases, extremes, misses, multi-match, drain to empty
        send_command(CMD_POP_FRONT, $urandom());
        send_command(CMD_POP_BACK, $urandom());
        send_command(CMD_DEL_FIRST, 32'h0000_0000);
        send_command(CMD_DEL_ALL, 32'hFFFF_FFFF);
        send_command(CMD_SPARE_A, $urandom());
        send_command(CMD_PUSH_BACK, 32'h8000_0000);
        send_command(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
        send_command(CMD_PUSH_BACK, 32'h0000_0000);
        send_command(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        send_command(CMD_PUSH_BACK, 32'h7FFF_FFFF);
        send_command(CMD_SPARE_B, $urandom());
        send_command(CMD_DEL_FIRST, 32'h0000_3039);
        send_command(CMD_DEL_ALL, 32'h5555_5555);
        send_command(CMD_DEL_FIRST, 32'h7FFF_FFFF);
        send_command(CMD_PUSH_BACK, 32'h7FFF_FFFF);
        send_command(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
        send_command(CMD_DEL_ALL, 32'h7FFF_FFFF);
        send_command(CMD_POP_FRONT, $urandom());
        send_command(CMD_POP_BACK, $urandom());
        send_command(CMD_DEL_FIRST, 32'h8000_0000);
        send_command(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
        send_command(CMD_DEL_ALL, 32'hAAAA_AAAA);
        send_command(CMD_POP_BACK, $urandom());

        quota = (ITEM_TARGET - sent_count) / 3;
        src_idle_pct   = 7;
        sink_stall_pct = 83;
        run_bursts(quota);
        src_idle_pct   = 83;
        sink_stall_pct = 7;
        run_bursts(quota);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_bursts(quota);

        cmd_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0)
            @(posedge clk);
        repeat (DEPTH + 10) @(posedge clk);

        $display("Sent %0d list commands and %0d unused codes; %0d results checked.",
                 sent_count, spare_count, chk_results);
        $display("Results included %0d full pushes, %0d on an empty list, %0d with no match.",
                 chk_full, chk_empty, chk_missing);
        if (chk_fail == 0 && chk_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timed out with %0d results outstanding", chk_pending);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
src/blvr_pkg.sv
src/blvr_ram.sv
src/bounded_list_with_value_removal.sv
sim/blvr_checker.sv
sim/tb_top.sv
